[sv/b2n_pkg.sv]
// ----------------------------------------------------------------------------
// b2n_pkg
// Shared types, sizes and coefficients of the BGRA to NV12 converter.
// ----------------------------------------------------------------------------
package b2n_pkg;

  // Frame geometry
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 13;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(1080);

  // Luma coefficients
  localparam int Y_R      = 66;
  localparam int Y_G      = 129;
  localparam int Y_B      = 25;
  localparam int Y_OFFSET = 16;

  // Chroma coefficients (magnitudes; signs are applied in the datapath)
  localparam int CB_R = 38;
  localparam int CB_G = 74;
  localparam int C_MAIN = 112;
  localparam int CR_G = 94;
  localparam int CR_B = 18;
  localparam int CHROMA_OFFSET = 128;

  localparam int ROUND   = 128;
  localparam int PIX_MAX = 255;

  // Input transaction
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       frame_end;
  } result_t;

  // Horizontal pair sums, one line store entry
  typedef struct packed {
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } sums_t;

  // 2x2 block average
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } avg_t;

  localparam int SUMS_W = $bits(sums_t);

endpackage

[sv/bgra_to_nv12_converter.sv]
// Pipeline: an accepted pixel passes through stage 1, stage 2 and the output register.
// Throughput: one pixel per cycle unless the result side stalls; the line store
// takes one write or one read per pixel pair.
// Reset: counters and held pixel clear, frame size returns to 1920 x 1080.
// The line store is not cleared; an odd row reads only entries the even row wrote.
// Stalls on the result side propagate back through the pipeline to pixel_ready.
// ----------------------------------------------------------------------------
// bgra_to_nv12_converter
// BT.601 studio-range luma per pixel and 4:2:0 chroma per 2x2 block, with a
// line store of horizontal pair sums from each even row.
// ----------------------------------------------------------------------------
module bgra_to_nv12_converter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [b2n_pkg::SIZE_W-1:0]    wr_data,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  b2n_pkg::pixel_t               pixel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output b2n_pkg::result_t              result
);

  // Clear bit 0 and saturate to the legal range
  function automatic logic [b2n_pkg::SIZE_W-1:0] size_eff(
    input logic [b2n_pkg::SIZE_W-1:0] v,
    input logic [b2n_pkg::SIZE_W-1:0] hi
  );
    logic [b2n_pkg::SIZE_W-1:0] e;
    e = {v[b2n_pkg::SIZE_W-1:1], 1'b0};
    if (e < b2n_pkg::SIZE_W'(2)) begin
      e = b2n_pkg::SIZE_W'(2);
    end
    if (e > hi) begin
      e = hi;
    end
    return e;
  endfunction

  logic [b2n_pkg::SIZE_W-1:0] width_eff, height_eff;
  logic [b2n_pkg::COL_W-1:0]  column_count;
  logic [b2n_pkg::ROW_W-1:0]  row_count;
  b2n_pkg::pixel_t            held_pixel;

  logic                       accept;
  logic                       last_col, last_row;
  b2n_pkg::sums_t             sums_now;
  logic                       line_wr, line_rd;
  logic [b2n_pkg::SLOT_W-1:0] slot;
  b2n_pkg::sums_t             line_entry;

  logic            s1_valid, s1_chroma, s1_end;
  b2n_pkg::pixel_t s1_pixel;
  b2n_pkg::sums_t  s1_sums;
  logic            s2_valid, s2_chroma, s2_end;
  logic [7:0]      s2_luma;
  b2n_pkg::avg_t   s2_avg;

  logic            out_free, s2_free, s1_free;
  logic            s1_move, s2_move;

  logic [16:0]     luma_acc;
  logic [9:0]      luma_sum;
  logic [7:0]      luma_now;
  logic [9:0]      blk_blue, blk_green, blk_red;
  b2n_pkg::avg_t   avg_now;
  logic [7:0]      cb_now, cr_now;

  // Store effective frame size on each register write
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= b2n_pkg::RESET_WIDTH;
      height_eff <= b2n_pkg::RESET_HEIGHT;
    end else if (wr_en) begin
      case (wr_index)
        b2n_pkg::REG_FRAME_WIDTH:
          width_eff <= size_eff(wr_data, b2n_pkg::SIZE_W'(b2n_pkg::MAX_WIDTH));
        b2n_pkg::REG_FRAME_HEIGHT:
          height_eff <= size_eff(wr_data, b2n_pkg::SIZE_W'(b2n_pkg::MAX_HEIGHT));
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control
  always_comb begin
    out_free    = ~result_valid | result_ready;
    s2_free     = ~s2_valid | out_free;
    s1_free     = ~s1_valid | s2_free;
    s2_move     = s2_valid & out_free;
    s1_move     = s1_valid & s2_free;
    pixel_ready = s1_free;
    accept      = pixel_valid & pixel_ready;
  end

  // Position tests and pair sums for the incoming pixel
  always_comb begin
    last_col       = ({1'b0, column_count} + b2n_pkg::SIZE_W'(1)) >= width_eff;
    last_row       = ({1'b0, row_count} + b2n_pkg::SIZE_W'(1)) >= height_eff;
    slot           = column_count[b2n_pkg::COL_W-1:1];
    sums_now.blue  = {1'b0, pixel.blue} + {1'b0, held_pixel.blue};
    sums_now.green = {1'b0, pixel.green} + {1'b0, held_pixel.green};
    sums_now.red   = {1'b0, pixel.red} + {1'b0, held_pixel.red};
    line_wr        = accept & column_count[0] & ~row_count[0];
    line_rd        = accept & column_count[0] & row_count[0];
  end

  // Advance position and hold the first pixel of each pair
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_pixel   <= '0;
    end else if (accept) begin
      if (!column_count[0]) begin
        held_pixel <= pixel;
      end
      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + b2n_pkg::ROW_W'(1);
        end
      end else begin
        column_count <= column_count + b2n_pkg::COL_W'(1);
      end
    end
  end

  // Line store of even-row pair sums
  b2n_ram #(
    .WIDTH (b2n_pkg::SUMS_W),
    .DEPTH (b2n_pkg::LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (slot),
    .wr_data (sums_now),
    .rd_en   (line_rd),
    .rd_addr (slot),
    .rd_data (line_entry)
  );

  // Stage 1: capture the accepted transaction alongside the line read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel  <= pixel;
      s1_sums   <= sums_now;
      s1_chroma <= column_count[0] & row_count[0];
      s1_end    <= last_col & last_row;
    end
  end

  // Luma and block averages
  always_comb begin
    luma_acc = 17'(b2n_pkg::Y_R * s1_pixel.red) + 17'(b2n_pkg::Y_G * s1_pixel.green)
             + 17'(b2n_pkg::Y_B * s1_pixel.blue) + 17'(b2n_pkg::ROUND);
    luma_sum = {1'b0, luma_acc[16:8]} + 10'(b2n_pkg::Y_OFFSET);
    if (luma_sum > 10'(b2n_pkg::PIX_MAX)) begin
      luma_now = 8'(b2n_pkg::PIX_MAX);
    end else begin
      luma_now = luma_sum[7:0];
    end
    blk_blue      = {1'b0, s1_sums.blue} + {1'b0, line_entry.blue};
    blk_green     = {1'b0, s1_sums.green} + {1'b0, line_entry.green};
    blk_red       = {1'b0, s1_sums.red} + {1'b0, line_entry.red};
    avg_now.blue  = blk_blue[9:2];
    avg_now.green = blk_green[9:2];
    avg_now.red   = blk_red[9:2];
  end

  // Stage 2: luma and averages
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_luma   <= luma_now;
      s2_avg    <= avg_now;
      s2_chroma <= s1_chroma;
      s2_end    <= s1_end;
    end
  end

  b2n_chroma u_chroma (
    .avg         (s2_avg),
    .chroma_blue (cb_now),
    .chroma_red  (cr_now)
  );

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      result.luma         <= s2_luma;
      result.chroma_valid <= s2_chroma;
      result.chroma_blue  <= s2_chroma ? cb_now : 8'd0;
      result.chroma_red   <= s2_chroma ? cr_now : 8'd0;
      result.frame_end    <= s2_end;
    end
  end

endmodule

[sv/b2n_ram.sv]
// ----------------------------------------------------------------------------
// b2n_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module b2n_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and hold the read data unless a read is requested
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/b2n_chroma.sv]
// ----------------------------------------------------------------------------
// b2n_chroma
// BT.601 studio-range Cb and Cr from a 2x2 block average, rounded and clamped.
// ----------------------------------------------------------------------------
module b2n_chroma (
  input  b2n_pkg::avg_t avg,
  output logic [7:0]    chroma_blue,
  output logic [7:0]    chroma_red
);

  // Rounding plus the offset of 128 moved above the shift keeps every sum positive
  localparam int BIAS = b2n_pkg::ROUND + (b2n_pkg::CHROMA_OFFSET << 8);

  logic [16:0] cb_pos, cb_neg, cb_diff;
  logic [16:0] cr_pos, cr_neg, cr_diff;

  // Form the positive and negative partial sums
  always_comb begin
    cb_pos  = 17'(b2n_pkg::C_MAIN * avg.blue) + 17'(BIAS);
    cb_neg  = 17'(b2n_pkg::CB_R * avg.red) + 17'(b2n_pkg::CB_G * avg.green);
    cb_diff = cb_pos - cb_neg;
    cr_pos  = 17'(b2n_pkg::C_MAIN * avg.red) + 17'(BIAS);
    cr_neg  = 17'(b2n_pkg::CR_G * avg.green) + 17'(b2n_pkg::CR_B * avg.blue);
    cr_diff = cr_pos - cr_neg;
  end

  // Shift down and clamp to the byte range
  always_comb begin
    if (cb_diff[16]) begin
      chroma_blue = 8'(b2n_pkg::PIX_MAX);
    end else begin
      chroma_blue = cb_diff[15:8];
    end
    if (cr_diff[16]) begin
      chroma_red = 8'(b2n_pkg::PIX_MAX);
    end else begin
      chroma_red = cr_diff[15:8];
    end
  end

endmodule
